// ===== rtl/core/keypad_led_select_blink_assert.svh =====
// assertion macros shared by the keypad led select blink rtl
`ifndef KEYPAD_LED_SELECT_BLINK_ASSERT_SVH
`define KEYPAD_LED_SELECT_BLINK_ASSERT_SVH

`ifndef ASSERT_OFF
// implication checked on every clock edge outside reset
`define KLSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition that must never be true outside reset
`define KLSB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define KLSB_ASSERT(lbl, prop, msg)
`define KLSB_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/klsb_pkg.sv =====
// types and constants of the keypad led select blink block
package klsb_pkg;

  localparam int unsigned LED_COUNT_DEF = 4;
  localparam int unsigned HOLD_W        = 4;
  localparam int unsigned DELAY_W       = 8;
  localparam int unsigned SEL_W         = 2;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 16;

  localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = 4'd3;
  localparam logic [DELAY_W-1:0] DELAY_MAX      = 8'hff;

  // one fire flag per button
  typedef struct packed {
    logic slower;
    logic faster;
    logic prev;
    logic next;
  } fire_t;

  // result item, selected_led in the lowest bits
  typedef struct packed {
    logic [DELAY_W-1:0] delay_now;
    logic               led_lit;
    logic [SEL_W-1:0]   selected_led;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ===== rtl/core/keypad_led_select_blink.sv =====
// top level of the keypad led select blink block
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | one tick with four button levels
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | led index, lit level, delay
//  cfg      | in        | cfg_valid_i / cfg_ready_o      | hold_ticks (4 bit)
//
// every accepted item produces exactly one result item, registered in the output buffer
// one item per cycle unless stalled; state update is a single pass of small adds and compares
// results sit in a two-entry buffer, so a stalled m_axis side blocks input only once both are full
// rst_ni clears hold counters, led index, delay and blink count, lights the first led
// and loads hold_ticks with 3; cfg is always ready
module keypad_led_select_blink import klsb_pkg::*; #(
  parameter int unsigned LED_COUNT = LED_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [HOLD_W-1:0]      cfg_data_i,    // hold_ticks
  // tick items in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] next_pressed, [1] prev_pressed, [2] faster_pressed, [3] slower_pressed, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // result items out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] selected_led, [2] led_lit, [10:3] delay_now, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [HOLD_W-1:0] hold_ticks_q;
  logic              step;
  fire_t             fire;
  result_t           res_in, res_out;

  // hold time register; the user must write it only while idle, the block does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_TICKS_RST;
    end else if (cfg_valid_i) begin
      hold_ticks_q <= cfg_data_i;
    end
  end

  // one accepted item advances all state by one tick
  assign step = s_axis_tvalid & s_axis_tready;

  // per-button hold counters decide which actions fire
  klsb_hold u_hold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .level_i      (s_axis_tdata[3:0]),
    .hold_ticks_i (hold_ticks_q),
    .fire_o       (fire)
  );

  // actions in order next, previous, faster, slower, then the blink step
  klsb_state #(
    .LED_COUNT (LED_COUNT)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .fire_i   (fire),
    .result_o (res_in)
  );

  // result register with skid stage toward m_axis
  klsb_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .data_i      (res_in),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (res_out)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), res_out};

endmodule

// ===== rtl/core/klsb_hold.sv =====
// hold counters for the four buttons, one fire flag each
module klsb_hold import klsb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [3:0]        level_i,
  input  logic [HOLD_W-1:0] hold_ticks_i,
  output fire_t             fire_o
);

  logic [HOLD_W-1:0] cnt_q [4];
  logic [HOLD_W-1:0] cnt_d [4];
  logic [3:0]        fire;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      fire[b]  = 1'b0;
      cnt_d[b] = '0;
      if (level_i[b]) begin
        if (cnt_q[b] < hold_ticks_i) begin
          cnt_d[b] = cnt_q[b] + HOLD_W'(1);
        end else begin
          fire[b] = 1'b1;
        end
      end
    end
  end

  assign fire_o = '{slower: fire[3], faster: fire[2], prev: fire[1], next: fire[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 4; b++) cnt_q[b] <= '0;
    end else if (step_i) begin
      for (int b = 0; b < 4; b++) cnt_q[b] <= cnt_d[b];
    end
  end

endmodule

// ===== rtl/core/klsb_state.sv =====
// led index, blink delay and blink phase registers with their update
`include "keypad_led_select_blink_assert.svh"

module klsb_state import klsb_pkg::*; #(
  parameter int unsigned LED_COUNT = LED_COUNT_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  fire_t   fire_i,
  output result_t result_o
);

  localparam int unsigned IdxW = $clog2(LED_COUNT);
  localparam logic [IdxW:0] LedCnt = (IdxW+1)'(LED_COUNT);

  logic [IdxW-1:0]    idx_q, idx_d, idx_n;
  logic               lit_q, lit_d;
  logic [DELAY_W-1:0] delay_q, delay_d, delay_f;
  logic [DELAY_W-1:0] elapsed_q, elapsed_d, elapsed_a;
  logic [IdxW:0]      idx_inc;
  logic               moved;
  logic [IdxW+1:0]    sel_wide;

  always_comb begin
    // next, then previous, with wrap-around
    idx_inc = {1'b0, idx_q} + (IdxW+1)'(1);
    idx_n   = idx_q;
    if (fire_i.next) begin
      idx_n = (idx_inc >= LedCnt) ? '0 : idx_inc[IdxW-1:0];
    end
    idx_d = idx_n;
    if (fire_i.prev) begin
      idx_d = (idx_n == '0 || {1'b0, idx_n} >= LedCnt) ? IdxW'(LED_COUNT - 1)
                                                     : idx_n - IdxW'(1);
    end
    moved     = fire_i.next | fire_i.prev;
    elapsed_a = moved ? '0 : elapsed_q;

    // faster then slower, both saturating
    delay_f = delay_q;
    if (fire_i.faster && delay_q != '0) delay_f = delay_q - DELAY_W'(1);
    delay_d = delay_f;
    if (fire_i.slower && delay_f != DELAY_MAX) delay_d = delay_f + DELAY_W'(1);

    // blink step
    lit_d = lit_q | moved;
    if (elapsed_a < delay_d) begin
      elapsed_d = elapsed_a + DELAY_W'(1);
    end else begin
      lit_d     = ~lit_d;
      elapsed_d = '0;
    end
  end

  assign sel_wide = {2'b00, idx_d};
  assign result_o = '{delay_now: delay_d, led_lit: lit_d, selected_led: sel_wide[SEL_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      lit_q     <= 1'b1;
      delay_q   <= '0;
      elapsed_q <= '0;
    end else if (step_i) begin
      idx_q     <= idx_d;
      lit_q     <= lit_d;
      delay_q   <= delay_d;
      elapsed_q <= elapsed_d;
    end
  end

  `KLSB_NEVER(a_idx_range, ({1'b0, idx_q} >= LedCnt), "led index out of range")
  `KLSB_ASSERT(a_delay_no_wrap_up, step_i && delay_q == DELAY_MAX |=> delay_q != '0, "delay wrapped up")
  `KLSB_ASSERT(a_delay_no_wrap_dn, step_i && delay_q == '0 |=> delay_q != DELAY_MAX, "delay wrapped down")

endmodule

// ===== rtl/core/klsb_outbuf.sv =====
// two-entry output buffer: result register plus skid register
`include "keypad_led_select_blink_assert.svh"

module klsb_outbuf import klsb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_ready_i,
  output result_t data_o
);

  result_t main_q, skid_q;
  logic    main_valid_q, skid_valid_q;
  logic    pop;

  assign pop     = main_valid_q & pop_ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) skid_valid_q <= 1'b0;
      end else if (push_i) begin
        if (!main_valid_q || pop) main_valid_q <= 1'b1;
        else                      skid_valid_q <= 1'b1;
      end else if (pop) begin
        main_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) main_q <= skid_q;
    end else if (push_i) begin
      if (!main_valid_q || pop) main_q <= data_i;
      else                      skid_q <= data_i;
    end
  end

  `KLSB_NEVER(a_skid_needs_main, skid_valid_q && !main_valid_q, "skid full with result empty")
  `KLSB_ASSERT(a_skid_fills, push_i && ready_o && main_valid_q && !pop |=> skid_valid_q, "stalled item lost")
  `KLSB_ASSERT(a_skid_drains, pop && skid_valid_q |=> main_valid_q && main_q == $past(skid_q), "skid item not moved")

endmodule
